// ===== hw/rtl/sfdc_pkg.sv =====
// Package for the state feedback drive controller: shared types, step codes
// and fixed point helper functions. No dependencies.
`default_nettype none
package sfdc_pkg;

   localparam int CSCALE = 100000;
   localparam int QW     = 32;   // Q value width
   localparam int PW     = 48;   // product and feedback sum width
   localparam int SW     = 5;    // step counter width

   // register indexes of the configuration port
   localparam logic [7:0] REG_REFERENCE_SPEED = 8'd0;
   localparam logic [7:0] REG_POWER_LIMIT     = 8'd1;

   // sequencer steps, one shared multiplication each
   localparam logic [SW-1:0] STEP_HEAD = 5'd0;
   localparam logic [SW-1:0] STEP_NXL  = 5'd1;
   localparam logic [SW-1:0] STEP_NXR  = 5'd2;
   localparam logic [SW-1:0] STEP_LM0  = 5'd3;
   localparam logic [SW-1:0] STEP_LM2  = 5'd5;
   localparam logic [SW-1:0] STEP_RM0  = 5'd6;
   localparam logic [SW-1:0] STEP_RM2  = 5'd8;
   localparam logic [SW-1:0] STEP_INT0 = 5'd9;
   localparam logic [SW-1:0] STEP_INT1 = 5'd10;
   localparam logic [SW-1:0] STEP_LFB0 = 5'd11;
   localparam logic [SW-1:0] STEP_LKI0 = 5'd16;
   localparam logic [SW-1:0] STEP_LKI1 = 5'd17;
   localparam logic [SW-1:0] STEP_RFB0 = 5'd18;
   localparam logic [SW-1:0] STEP_RKI0 = 5'd23;
   localparam logic [SW-1:0] STEP_RKI1 = 5'd24;
   localparam logic [SW-1:0] STEP_LAST = 5'd24;

   typedef enum logic [1:0] {CTL_IDLE, CTL_ISSUE, CTL_WAIT, CTL_DONE} ctl_state_type;
   typedef enum logic [1:0] {MUL_IDLE, MUL_RUN, MUL_ROUND} mul_state_type;

   typedef struct packed {
      logic start;
      logic round;
   } mul_ctl_type;

   // constant in units of 1e-5 to Q format, rounded half away from zero
   function automatic logic signed [QW-1:0] cfx(input int n, input int frac);
      longint m;
      m = (n < 0) ? -longint'(n) : longint'(n);
      m = ((m <<< frac) + CSCALE / 2) / CSCALE;
      return QW'((n < 0) ? -m : m);
   endfunction

   // coefficient of each sequencer step
   function automatic logic signed [QW-1:0] coef(input logic [SW-1:0] s, input int frac);
      logic signed [QW-1:0] c;
      case (s)
         5'd0:    c = cfx(15000, frac);
         5'd1:    c = cfx(-58570, frac);
         5'd2:    c = cfx(-1443060, frac);
         5'd3:    c = cfx(90240, frac);
         5'd4:    c = cfx(-7960, frac);
         5'd5:    c = cfx(7183, frac);
         5'd6:    c = cfx(90190, frac);
         5'd7:    c = cfx(-188300, frac);
         5'd8:    c = cfx(169800, frac);
         5'd9:    c = cfx(2000, frac);
         5'd10:   c = cfx(2000, frac);
         5'd11:   c = cfx(1601070, frac);
         5'd12:   c = cfx(307010, frac);
         5'd13:   c = cfx(845640, frac);
         5'd14:   c = cfx(-183070, frac);
         5'd15:   c = cfx(4460, frac);
         5'd16:   c = cfx(3217740, frac);
         5'd17:   c = cfx(606670, frac);
         5'd18:   c = cfx(-884800, frac);
         5'd19:   c = cfx(-19640, frac);
         5'd20:   c = cfx(14200, frac);
         5'd21:   c = cfx(151250, frac);
         5'd22:   c = cfx(39610, frac);
         5'd23:   c = cfx(-505740, frac);
         5'd24:   c = cfx(646770, frac);
         default: c = '0;
      endcase
      return c;
   endfunction

   // saturate a wide signed value to the 32-bit signed range
   function automatic logic signed [QW-1:0] sat32(input logic signed [PW-1:0] v);
      logic signed [QW-1:0] r;
      if (v > PW'(signed'(32'h7FFF_FFFF)))      r = 32'sh7FFF_FFFF;
      else if (v < PW'(signed'(32'h8000_0000))) r = 32'sh8000_0000;
      else                                      r = v[QW-1:0];
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sfdc_mul.sv =====
// Bit-serial signed multiplier: one multiplier bit per cycle, then an
// optional round half away from zero by FRAC_BITS. Uses sfdc_pkg.
`default_nettype none
module sfdc_mul
   import sfdc_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire mul_ctl_type          ctl,
   input  wire logic signed [QW-1:0] mul_a,
   input  wire logic signed [QW-1:0] mul_b,
   output logic                      done,
   output logic signed [PW-1:0]      product
);

   mul_state_type state_ff, state_in;
   logic [4:0]          cnt_ff, cnt_in;
   logic [QW-1:0]       mcand_ff, mcand_in;
   logic [2*QW-1:0]     prod_ff, prod_in;
   logic                neg_ff, neg_in, round_ff, round_in;
   logic signed [PW-1:0] product_ff, product_in;
   logic                done_ff, done_in;
   logic [QW:0]         part_sum;
   logic [2*QW-1:0]     rounded;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         MUL_IDLE:  if (ctl.start) state_in = MUL_RUN;
         MUL_RUN:   if (cnt_ff == 5'd31) state_in = MUL_ROUND;
         MUL_ROUND: state_in = MUL_IDLE;
         default:   state_in = MUL_IDLE;
      endcase
   end

   // shift-add datapath and rounding
   always_comb begin
      cnt_in     = cnt_ff;
      mcand_in   = mcand_ff;
      prod_in    = prod_ff;
      neg_in     = neg_ff;
      round_in   = round_ff;
      product_in = product_ff;
      done_in    = 1'b0;
      part_sum   = {1'b0, prod_ff[2*QW-1:QW]} + (prod_ff[0] ? {1'b0, mcand_ff} : '0);
      rounded    = round_ff ? ((prod_ff + (64'(1) << (FRAC_BITS - 1))) >> FRAC_BITS)
                            : prod_ff;
      case (state_ff)
         MUL_IDLE: begin
            if (ctl.start) begin
               neg_in   = mul_a[QW-1] ^ mul_b[QW-1];
               round_in = ctl.round;
               mcand_in = mul_a[QW-1] ? QW'(-mul_a) : QW'(mul_a);
               prod_in  = {32'd0, (mul_b[QW-1] ? QW'(-mul_b) : QW'(mul_b))};
               cnt_in   = '0;
            end
         end
         MUL_RUN: begin
            prod_in = {part_sum, prod_ff[QW-1:1]};
            cnt_in  = cnt_ff + 5'd1;
         end
         MUL_ROUND: begin
            product_in = neg_ff ? -signed'(rounded[PW-1:0]) : signed'(rounded[PW-1:0]);
            done_in    = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MUL_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff     <= cnt_in;
      mcand_ff   <= mcand_in;
      prod_ff    <= prod_in;
      neg_ff     <= neg_in;
      round_ff   <= round_in;
      product_ff <= product_in;
   end

   assign done    = done_ff;
   assign product = product_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/state_feedback_drive_controller.sv =====
// State feedback drive controller with integral action, top level.
// Uses sfdc_pkg and sfdc_mul.
//
// Usage: each word on the req_ channel is one control tick carrying the two
// encoder distances and speed counts; req_tuser is the restart flag. Each
// tick gives exactly one word on the rsp_ channel with the two clamped drive
// powers and the two current model estimates. The csr_ channel writes the
// reference speed (index 0) and the power limit (index 1); it is always
// ready. The user must write it only while no tick is in progress; the
// block itself does not enforce this. Timing: a tick runs as 25
// multiplications on one bit-serial multiplier, each made of issue, a
// shift-add step per multiplier bit, rounding and write back; the next tick
// can be accepted as soon as the result word is valid. A restart tick skips
// the multiplications and goes straight to the done state. One tick is in
// progress at a time, and req_tready is high only when the sequencer is free.
// The result sits in an output register: a stalled receiver does not stop
// the next tick from being accepted, but a finished tick waits for the
// register to drain before it is written.
// Reset clears the integrators, the models, the commands and the output,
// sets the reference speed to 0 and the power limit to 120.
`default_nettype none
module state_feedback_drive_controller
   import sfdc_pkg::*;
#(
   parameter int FRAC_BITS  = 16,
   parameter int COUNT_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // left_distance[15:0], right_distance[31:16], left_speed_count[41:32],
   // right_speed_count[51:42], zero fill
   input  wire logic [55:0] req_tdata,
   // restart
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // left_power[7:0], right_power[15:8], left_current_estimate[31:16],
   // right_current_estimate[47:32]
   output logic [47:0]      rsp_tdata,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_index,
   input  wire logic [7:0]  csr_data
);

   localparam int CB = (COUNT_BITS < 16) ? COUNT_BITS : 16;
   localparam logic [15:0] DIST_MASK = 16'((17'(1) << CB) - 17'(1));

   ctl_state_type state_ff, state_in;
   logic [SW-1:0] step_ff, step_in;
   logic [7:0]    ref_ff, ref_in, limit_ff, limit_in;
   logic [15:0]   dl_ff, dl_in, dr_ff, dr_in;
   logic [9:0]    sl_ff, sl_in, sr_ff, sr_in;
   logic signed [QW-1:0] x0_ff, x0_in, des2_ff, des2_in, des4_ff, des4_in;
   logic signed [QW-1:0] hl_ff [3], hl_in [3], hr_ff [3], hr_in [3];
   logic signed [QW-1:0] int_ff [2], int_in [2];
   logic [7:0]    cmd_ff [2], cmd_in [2];
   logic signed [PW-1:0] acc_ff, acc_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [47:0]   rsp_data_ff, rsp_data_in;

   logic signed [QW-1:0] r_q, x1, x3, mul_b;
   logic signed [QW-1:0] err [5];
   logic signed [16:0]   dist_diff;
   logic signed [PW-1:0] product, acc_sum;
   logic          mul_done, out_free;
   mul_ctl_type   mul_ctl;

   function automatic logic signed [QW-1:0] to_q(input logic [9:0] n);
      return sat32(signed'(PW'(n) << FRAC_BITS));
   endfunction

   function automatic logic [7:0] to_power(input logic signed [PW-1:0] v,
                                           input logic [7:0] lim);
      logic signed [PW-1:0] ip;
      logic [7:0] p;
      ip = v >>> FRAC_BITS;
      if (v < 0)                     p = 8'd0;
      else if (ip > PW'(lim))        p = lim;
      else                           p = ip[7:0];
      return p;
   endfunction

   function automatic logic [15:0] int_part16(input logic signed [QW-1:0] v);
      logic [QW:0] m;
      logic signed [QW+1:0] ip;
      logic [15:0] r;
      m  = v[QW-1] ? (QW+1)'(-signed'({v[QW-1], v})) : {1'b0, v};
      m  = m >> FRAC_BITS;
      ip = v[QW-1] ? -signed'({1'b0, m}) : signed'({1'b0, m});
      if (ip > 34'sd32767)       r = 16'h7FFF;
      else if (ip < -34'sd32768) r = 16'h8000;
      else                       r = ip[15:0];
      return r;
   endfunction

   // operands and errors
   assign dist_diff = signed'({1'b0, dl_ff}) - signed'({1'b0, dr_ff});
   assign r_q       = sat32(signed'(PW'(signed'(ref_ff))) <<< FRAC_BITS);
   assign x1        = to_q(sl_ff);
   assign x3        = to_q(sr_ff);
   assign err[0]    = sat32(-PW'(x0_ff));
   assign err[1]    = sat32(PW'(r_q) - PW'(x1));
   assign err[2]    = sat32(PW'(des2_ff) - PW'(hl_ff[0]));
   assign err[3]    = sat32(PW'(r_q) - PW'(x3));
   assign err[4]    = sat32(PW'(des4_ff) - PW'(hr_ff[0]));
   assign acc_sum   = acc_ff + product;
   assign out_free  = !rsp_valid_ff || rsp_tready;

   // pick the multiplicand of each step
   always_comb begin
      case (step_ff) inside
         STEP_HEAD:             mul_b = QW'(dist_diff);
         STEP_NXL, STEP_NXR:    mul_b = r_q;
         [STEP_LM0:STEP_LM2]:   mul_b = hl_ff[2'(step_ff - STEP_LM0)];
         [STEP_RM0:STEP_RM2]:   mul_b = hr_ff[2'(step_ff - STEP_RM0)];
         STEP_INT0:             mul_b = err[0];
         STEP_INT1:             mul_b = err[1];
         [STEP_LFB0:STEP_LFB0+5'd4]: mul_b = err[3'(step_ff - STEP_LFB0)];
         [STEP_RFB0:STEP_RFB0+5'd4]: mul_b = err[3'(step_ff - STEP_RFB0)];
         STEP_LKI0, STEP_RKI0:  mul_b = int_ff[0];
         STEP_LKI1, STEP_RKI1:  mul_b = int_ff[1];
         default:               mul_b = '0;
      endcase
   end

   sfdc_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mul_ctl),
      .mul_a   (coef(step_ff, FRAC_BITS)),
      .mul_b   (mul_b),
      .done    (mul_done),
      .product (product)
   );

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CTL_IDLE:  if (req_tvalid) state_in = req_tuser ? CTL_DONE : CTL_ISSUE;
         CTL_ISSUE: state_in = CTL_WAIT;
         CTL_WAIT: begin
            if (mul_done) state_in = (step_ff == STEP_LAST) ? CTL_DONE : CTL_ISSUE;
         end
         CTL_DONE:  if (out_free) state_in = CTL_IDLE;
         default:   state_in = CTL_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready    = (state_ff == CTL_IDLE);
      mul_ctl.start = (state_ff == CTL_ISSUE);
      mul_ctl.round = (step_ff != STEP_HEAD);
   end

   // datapath: capture, write back, result word
   always_comb begin
      step_in = step_ff;  ref_in = ref_ff;  limit_in = limit_ff;
      dl_in = dl_ff;  dr_in = dr_ff;  sl_in = sl_ff;  sr_in = sr_ff;
      x0_in = x0_ff;  des2_in = des2_ff;  des4_in = des4_ff;
      hl_in = hl_ff;  hr_in = hr_ff;  int_in = int_ff;  cmd_in = cmd_ff;
      acc_in = acc_ff;
      rsp_valid_in = rsp_valid_ff;  rsp_data_in = rsp_data_ff;

      // configuration
      if (csr_valid) begin
         if (csr_index == REG_REFERENCE_SPEED) ref_in = csr_data;
         else if (csr_index == REG_POWER_LIMIT) limit_in = csr_data;
      end

      // take a tick word; restart clears the loop state
      if (state_ff == CTL_IDLE && req_tvalid) begin
         step_in = STEP_HEAD;
         dl_in   = req_tdata[15:0] & DIST_MASK;
         dr_in   = req_tdata[31:16] & DIST_MASK;
         sl_in   = req_tdata[41:32];
         sr_in   = req_tdata[51:42];
         if (req_tuser) begin
            hl_in  = '{default: '0};
            hr_in  = '{default: '0};
            int_in = '{default: '0};
            cmd_in = '{default: '0};
         end
      end

      // write back one product; wrap the step counter after the last one
      if (state_ff == CTL_WAIT && mul_done) begin
         step_in = (step_ff == STEP_LAST) ? STEP_HEAD : step_ff + 5'd1;
         case (step_ff) inside
            STEP_HEAD: x0_in = sat32(product);
            STEP_NXL:  des2_in = sat32(product);
            STEP_NXR:  des4_in = sat32(product);
            STEP_LM0, STEP_RM0, STEP_LFB0, STEP_RFB0: acc_in = product;
            STEP_LM2: begin
               hl_in[2] = hl_ff[1];
               hl_in[1] = to_q({2'b00, cmd_ff[0]});
               hl_in[0] = sat32(acc_sum);
            end
            STEP_RM2: begin
               hr_in[2] = hr_ff[1];
               hr_in[1] = to_q({2'b00, cmd_ff[1]});
               hr_in[0] = sat32(acc_sum);
            end
            STEP_INT0: int_in[0] = sat32(PW'(int_ff[0]) + product);
            STEP_INT1: int_in[1] = sat32(PW'(int_ff[1]) + product);
            STEP_LKI1: cmd_in[0] = to_power(acc_sum, limit_ff);
            STEP_RKI1: cmd_in[1] = to_power(acc_sum, limit_ff);
            default:   acc_in = acc_sum;
         endcase
      end

      // hand over the result word
      if (rsp_tready) rsp_valid_in = 1'b0;
      if (state_ff == CTL_DONE && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {int_part16(hr_ff[0]), int_part16(hl_ff[0]), cmd_ff[1], cmd_ff[0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTL_IDLE;
         step_ff      <= STEP_HEAD;
         ref_ff       <= 8'd0;
         limit_ff     <= 8'd120;
         hl_ff        <= '{default: '0};
         hr_ff        <= '{default: '0};
         int_ff       <= '{default: '0};
         cmd_ff       <= '{default: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         ref_ff       <= ref_in;
         limit_ff     <= limit_in;
         hl_ff        <= hl_in;
         hr_ff        <= hr_in;
         int_ff       <= int_in;
         cmd_ff       <= cmd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dl_ff       <= dl_in;
      dr_ff       <= dr_in;
      sl_ff       <= sl_in;
      sr_ff       <= sr_in;
      x0_ff       <= x0_in;
      des2_ff     <= des2_in;
      des4_ff     <= des4_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   // multiplier finishes only while the sequencer waits for it
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> state_ff == CTL_WAIT) else $error("product outside wait");

   // step counter stays within the step list
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= STEP_LAST) else $error("step out of range");

   // a new result word comes only from the done state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == CTL_DONE))
      else $error("result word without finished tick");

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// Testbench for state_feedback_drive_controller: drives control ticks and
// register writes, predicts every result word in fixed point and checks it.
// Depends on sfdc_pkg and the controller RTL.
`timescale 1ns / 100ps
module testbench;
   import sfdc_pkg::*;

   localparam int FB = 16;
   localparam int CB = 16;
   localparam longint QMAX = 64'sd2147483647;
   localparam longint QMIN = -64'sd2147483648;

   typedef struct packed {
      logic [15:0] right_est;
      logic [15:0] left_est;
      logic [7:0]  right_pwr;
      logic [7:0]  left_pwr;
   } drive_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;

   state_feedback_drive_controller uut (.*);

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor copy of the controller state and registers
   logic [7:0] ref_speed_reg;
   logic [7:0] limit_reg;
   longint     integ [2];
   longint     lhist [3];
   longint     rhist [3];
   logic [7:0] last_cmd [2];

   drive_word_type expected_words [$];
   int  fail_count = 0;
   bit  calm = 1'b0;

   // gain tables, units of 1e-5
   int kgain [2][5] = '{'{1601070, 307010, 845640, -183070, 4460},
                        '{-884800, -19640, 14200, 151250, 39610}};
   int kigain [2][2] = '{'{3217740, 606670}, '{-505740, 646770}};
   int lcoef [3] = '{90240, -7960, 7183};
   int rcoef [3] = '{90190, -188300, 169800};

   function automatic longint to_fixed(int n);
      longint m;
      m = (n < 0) ? -longint'(n) : longint'(n);
      m = ((m << FB) + 50000) / 100000;
      return (n < 0) ? -m : m;
   endfunction

   function automatic longint clip32(longint v);
      if (v > QMAX) return QMAX;
      if (v < QMIN) return QMIN;
      return v;
   endfunction

   function automatic longint fmul(longint a, longint b);
      longint p, m;
      p = a * b;
      m = (p < 0) ? -p : p;
      m = (m + (64'sd1 << (FB - 1))) >>> FB;
      return (p < 0) ? -m : m;
   endfunction

   function automatic logic [15:0] est_int(longint v);
      longint m;
      m = (v < 0) ? -v : v;
      m = m >>> FB;
      if (v < 0) m = -m;
      if (m > 32767) m = 32767;
      if (m < -32768) m = -32768;
      return m[15:0];
   endfunction

   function automatic logic [7:0] power_of(longint v);
      longint ip;
      if (v < 0) return 8'd0;
      ip = v >>> FB;
      return (ip > limit_reg) ? limit_reg : ip[7:0];
   endfunction

   function automatic void clear_plant();
      integ = '{0, 0};
      lhist = '{0, 0, 0};
      rhist = '{0, 0, 0};
      last_cmd = '{8'd0, 8'd0};
   endfunction

   // one control tick of the predictor
   function automatic drive_word_type predict_tick(logic [15:0] ld, logic [15:0] rd,
                                                   logic [9:0] ls, logic [9:0] rs,
                                                   logic rst);
      drive_word_type w;
      longint x [5], des [5], r, fb, yl, yr, e;
      longint cm;
      cm = (64'sd1 << CB) - 1;
      if (rst) begin
         clear_plant();
         return '0;
      end
      r = clip32(longint'($signed(ref_speed_reg)) <<< FB);
      des[0] = 0;
      des[1] = r;
      des[2] = clip32(fmul(to_fixed(-58570), r));
      des[3] = r;
      des[4] = clip32(fmul(to_fixed(-1443060), r));
      x[0] = clip32(((longint'(ld) & cm) - (longint'(rd) & cm)) * to_fixed(15000));
      x[1] = longint'(ls) <<< FB;
      yl = clip32(fmul(to_fixed(lcoef[0]), lhist[0]) + fmul(to_fixed(lcoef[1]), lhist[1])
                  + fmul(to_fixed(lcoef[2]), lhist[2]));
      lhist[2] = lhist[1];
      lhist[1] = longint'(last_cmd[0]) <<< FB;
      lhist[0] = yl;
      x[2] = yl;
      x[3] = longint'(rs) <<< FB;
      yr = clip32(fmul(to_fixed(rcoef[0]), rhist[0]) + fmul(to_fixed(rcoef[1]), rhist[1])
                  + fmul(to_fixed(rcoef[2]), rhist[2]));
      rhist[2] = rhist[1];
      rhist[1] = longint'(last_cmd[1]) <<< FB;
      rhist[0] = yr;
      x[4] = yr;
      for (int i = 0; i < 2; i++) begin
         e = clip32(des[i] - x[i]);
         integ[i] = clip32(integ[i] + fmul(to_fixed(2000), e));
      end
      for (int i = 0; i < 2; i++) begin
         fb = 0;
         for (int j = 0; j < 5; j++) fb += fmul(to_fixed(kgain[i][j]), clip32(des[j] - x[j]));
         for (int j = 0; j < 2; j++) fb += fmul(to_fixed(kigain[i][j]), integ[j]);
         last_cmd[i] = power_of(fb);
      end
      w.left_pwr = last_cmd[0];
      w.right_pwr = last_cmd[1];
      w.left_est = est_int(x[2]);
      w.right_est = est_int(x[4]);
      return w;
   endfunction

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      fail_count++;
   endtask

   function automatic bit idle_now();
      return !calm && ($urandom_range(99) < 7);
   endfunction

   // send one tick and queue its prediction; valid stays up until the next
   // falling edge so that one edge carries one assignment only
   task automatic send_tick(logic [15:0] ld, logic [15:0] rd, logic [9:0] ls,
                            logic [9:0] rs, logic rst);
      @(negedge clock);
      while (idle_now()) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata <= {4'd0, rs, ls, rd, ld};
      req_tuser <= rst;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_words.push_back(predict_tick(ld, rd, ls, rs, rst));
   endtask

   task automatic write_reg(logic [7:0] idx, logic [7:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == REG_REFERENCE_SPEED) ref_speed_reg = val;
      else if (idx == REG_POWER_LIMIT) limit_reg = val;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_words.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // receiver stalls
   always @(negedge clock) rsp_tready <= !idle_now();

   // check each result word against the oldest prediction
   always @(posedge clock) begin
      drive_word_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_words.size() == 0) begin
            report("unexpected word", 64'(rsp_tdata), 64'(0));
         end else begin
            want = expected_words.pop_front();
            if (got.left_pwr != want.left_pwr)
               report("left_power", 64'(got.left_pwr), 64'(want.left_pwr));
            if (got.right_pwr != want.right_pwr)
               report("right_power", 64'(got.right_pwr), 64'(want.right_pwr));
            if (got.left_est != want.left_est)
               report("left_est", 64'(got.left_est), 64'(want.left_est));
            if (got.right_est != want.right_est)
               report("right_est", 64'(got.right_est), 64'(want.right_est));
         end
      end
   end

   task automatic run_extremes();
      send_tick(16'h0000, 16'h0000, 10'd0, 10'd0, 1'b0);
      send_tick(16'hFFFF, 16'h0000, 10'd1023, 10'd0, 1'b0);
      send_tick(16'h0000, 16'hFFFF, 10'd0, 10'd1023, 1'b0);
      send_tick(16'hFFFF, 16'hFFFF, 10'd1023, 10'd1023, 1'b0);
      send_tick(16'h8000, 16'h7FFF, 10'd512, 10'd511, 1'b0);
      send_tick(16'h1234, 16'h1200, 10'd5, 10'd7, 1'b1);
      send_tick(16'h0100, 16'h0000, 10'd3, 10'd3, 1'b0);
   endtask

   task automatic run_registers();
      drain();
      write_reg(REG_REFERENCE_SPEED, 8'd127);
      write_reg(REG_POWER_LIMIT, 8'd255);
      for (int i = 0; i < 5; i++) send_tick(16'd100, 16'd90, 10'd0, 10'd0, 1'b0);
      drain();
      write_reg(REG_REFERENCE_SPEED, 8'h80);
      write_reg(REG_POWER_LIMIT, 8'd0);
      for (int i = 0; i < 4; i++) send_tick(16'd10, 16'd300, 10'd1023, 10'd1023, 1'b0);
      drain();
      // out-of-range index is ignored
      write_reg(8'd2, 8'd55);
      write_reg(8'hFF, 8'd9);
      write_reg(REG_POWER_LIMIT, 8'd120);
      send_tick(16'd0, 16'd0, 10'd0, 10'd0, 1'b1);
      send_tick(16'd7, 16'd2, 10'd20, 10'd20, 1'b0);
   endtask

   task automatic run_random(int n);
      logic [15:0] ld, rd;
      for (int i = 0; i < n; i++) begin
         if (i % 150 == 0) begin
            drain();
            write_reg(REG_REFERENCE_SPEED, 8'($urandom()));
            write_reg(REG_POWER_LIMIT, ($urandom_range(3) == 0) ? 8'd255 : 8'($urandom()));
         end
         calm = (i >= 400 && i < 550);
         ld = 16'($urandom());
         // mostly near-straight driving, sometimes wild distances
         rd = ($urandom_range(3) == 0) ? 16'($urandom()) : ld + 16'($urandom_range(60)) - 16'd30;
         send_tick(ld, rd, 10'($urandom_range(1023)), 10'($urandom_range(1023)),
                   $urandom_range(39) == 0);
      end
      calm = 1'b0;
   endtask

   initial begin
      ref_speed_reg = 8'd0;
      limit_reg = 8'd120;
      clear_plant();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      run_extremes();
      run_registers();
      run_random(1230);
      drain();
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // guard against a hung run; the limit leaves ample margin over the full regression
   initial begin
      #(64'd12 * 64'd8000000);
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule

// ===== filelist.f =====
hw/rtl/sfdc_pkg.sv
hw/rtl/sfdc_mul.sv
hw/rtl/state_feedback_drive_controller.sv
sim/testbench.sv
